[rtl/core/cartridge_bank_mapper_macros.svh]
// assertion macros shared by the cartridge bank mapper rtl
// no dependencies; included by modules that carry concurrent assertions
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CBM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cartridge bank mapper assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CBM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cartridge bank mapper assertion failed");

`endif

[rtl/core/cbm_pkg.sv]
// types and constants of the cartridge bank mapper
// no dependencies; imported by cbm_ctrl, cbm_datapath and cartridge_bank_mapper
`default_nettype none

package cbm_pkg;

    // field and register widths
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int PA_W      = 23;
    localparam int BANK_W    = 9;
    localparam int ROM_CNT_W = 10;
    localparam int RAM_CNT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;

    // bank count limits
    localparam logic [ROM_CNT_W-1:0] MAX_ROM_BANKS = 10'd512;
    localparam logic [RAM_CNT_W-1:0] MAX_RAM_BANKS = 5'd16;

    // one remainder bit per divide step
    localparam int DIV_STEPS  = BANK_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // mapper codes
    localparam logic [1:0] MAP_ROM_ONLY = 2'd0;
    localparam logic [1:0] MAP_MBC1     = 2'd1;
    localparam logic [1:0] MAP_MBC5     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_TYPE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 2'd2;

    // result target codes
    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_OPEN = 2'd2,
        TGT_NONE = 2'd3
    } target_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic step;
        logic last;
        logic load_out;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic quick;
    } stat_t;

endpackage

`default_nettype wire

[rtl/core/cartridge_bank_mapper.sv]
// Cartridge bank mapper (ROM only, MBC1, MBC5) for 16-bit CPU bus accesses.
// Each item is one bus access; each gives exactly one result item with the
// access target and physical ROM or RAM byte address.
// Input channel s_*: tdata = addr[15:0], wdata[23:16]; tuser = op (1 = write).
// Output channel m_*: tdata = phys_addr[22:0], zero in bit 23;
//   tuser = target[1:0], ram_write[2].
// Config channel cfg_*: index 0 mapper type, 1 ROM bank count, 2 RAM bank
//   count; cfg_ready is always high; write only while no item is in flight.
// An item skips the divider when its bank number is already below the bank
//   count, the count is zero, or it needs no reduction; otherwise the bank is
//   reduced by the shared restoring divider, one remainder bit per cycle. The
//   result enters the output register in the FINISH state after the last
//   divide step, once that register is free.
// A finished result waits in the output register while the next item is
//   taken in; if the receiver stalls, the block holds its next result and
//   drops s_tready until the output register frees.
// Reset (aresetn low, synchronous) restores the configuration and bank
//   registers to MBC1, 2 ROM banks, no RAM, ROM bank 1, RAM disabled.
`default_nettype none

module cartridge_bank_mapper
    import cbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    // bus access items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,   // addr[15:0], wdata[23:16]
    input  wire logic                 s_tuser,   // op[0]
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // phys_addr[22:0], zero pad [23]
    output logic [2:0]                m_tuser    // target[1:0], ram_write[2]
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencing
    cbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // decode, bank state and address translation
    cbm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/core/cbm_ctrl.sv]
// controller of the cartridge bank mapper: item sequencing and output valid
// depends on cbm_pkg and cartridge_bank_mapper_macros.svh
`default_nettype none
`include "cartridge_bank_mapper_macros.svh"

module cbm_ctrl
    import cbm_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    input  wire stat_t stat,
    output cmd_t      cmd
);

    typedef enum logic [1:0] {
        IDLE,
        DIVIDE,
        FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    out_free;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        cmd.accept    = s_tvalid && (state_reg == IDLE);
        unique case (state_reg)
            IDLE: begin
                if (cmd.accept) begin
                    cnt_next   = '0;
                    state_next = stat.quick ? FINISH : DIVIDE;
                end
            end
            DIVIDE: begin
                cmd.step = 1'b1;
                cmd.last = (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1));
                cnt_next = cnt_reg + 1'b1;
                if (cmd.last) begin
                    state_next = FINISH;
                end
            end
            FINISH: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // checks
    `CBM_ASSERT_IMPL(a_load_when_free, aclk, aresetn, cmd.load_out, !m_tvalid_reg || m_tready)
    `CBM_ASSERT_NEXT(a_quick_skips_divide, aclk, aresetn, cmd.accept && stat.quick, state_reg == FINISH)
    `CBM_ASSERT_IMPL(a_step_count_bound, aclk, aresetn, state_reg == DIVIDE, cnt_reg < STEP_CNT_W'(DIV_STEPS))

endmodule

`default_nettype wire

[rtl/core/cbm_datapath.sv]
// datapath of the cartridge bank mapper: config and bank registers, access
// decode, iterative bank reduction and output register; depends on cbm_pkg
`default_nettype none
`include "cartridge_bank_mapper_macros.svh"

module cbm_datapath
    import cbm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic [23:0]          s_tdata,
    input  wire logic                 s_tuser,
    input  wire cmd_t                 cmd,
    output stat_t                     stat,
    output logic [23:0]               m_tdata,
    output logic [2:0]                m_tuser
);

    // configuration
    logic [1:0]           mapper_type_reg;
    logic [ROM_CNT_W-1:0] rom_bank_count_reg;
    logic [RAM_CNT_W-1:0] ram_bank_count_reg;

    // bank state
    logic       ram_enabled_reg;
    logic [7:0] rom_bank_low_reg;
    logic       rom_bank_high_reg;
    logic [3:0] ram_bank_reg;
    logic       banking_mode_reg;

    // item registers
    target_t              tgt_reg;
    logic [PA_W-1:0]      base_reg;
    logic                 rw_reg;
    logic                 mod_reg;
    logic                 ram_sel_reg;
    logic [13:0]          off_reg;
    logic [BANK_W-1:0]    res_reg;
    logic [BANK_W-1:0]    dvd_reg;
    logic [ROM_CNT_W-1:0] dsr_reg;
    logic [ROM_CNT_W-1:0] rem_reg;
    logic [23:0]          m_tdata_reg;
    logic [2:0]           m_tuser_reg;

    // decode
    logic                 op;
    logic [ADDR_W-1:0]    addr;
    logic [DATA_W-1:0]    wdata;
    logic [1:0]           mt;
    logic                 in_rom;
    logic                 in_ram;
    logic [ROM_CNT_W-1:0] n_rom;
    logic [RAM_CNT_W-1:0] n_ram;
    target_t              dec_tgt;
    logic [PA_W-1:0]      dec_base;
    logic                 dec_rw;
    logic                 dec_mod;
    logic                 dec_ram_sel;
    logic [BANK_W-1:0]    dec_bank;
    logic [ROM_CNT_W-1:0] dec_n;
    logic                 reg_wr;

    // divide step and result
    logic [ROM_CNT_W-1:0] rem_shift;
    logic [ROM_CNT_W-1:0] rem_next;
    logic [PA_W-1:0]      pa;

    assign op    = s_tuser;
    assign addr  = s_tdata[15:0];
    assign wdata = s_tdata[23:16];

    assign mt = (mapper_type_reg == MAP_MBC1 || mapper_type_reg == MAP_MBC5) ?
                mapper_type_reg : MAP_ROM_ONLY;
    assign in_rom = !addr[15];
    assign in_ram = (addr[15:13] == 3'b101);
    assign n_rom  = (rom_bank_count_reg > MAX_ROM_BANKS) ? MAX_ROM_BANKS : rom_bank_count_reg;
    assign n_ram  = (ram_bank_count_reg > MAX_RAM_BANKS) ? MAX_RAM_BANKS : ram_bank_count_reg;
    assign reg_wr = cmd.accept && in_rom && op && (mt != MAP_ROM_ONLY);

    // access decode against the current bank state
    always_comb begin
        dec_tgt     = TGT_NONE;
        dec_base    = '0;
        dec_rw      = 1'b0;
        dec_mod     = 1'b0;
        dec_ram_sel = 1'b0;
        dec_bank    = '0;
        dec_n       = '0;
        if (in_rom && !op) begin
            dec_tgt = TGT_ROM;
            if (mt == MAP_ROM_ONLY) begin
                dec_base = PA_W'(addr);
            end else begin
                dec_mod = 1'b1;
                dec_n   = n_rom;
                if (mt == MAP_MBC1) begin
                    if (!addr[14]) begin
                        dec_bank = banking_mode_reg ? {ram_bank_reg, 5'b0} : '0;
                    end else begin
                        dec_bank = {ram_bank_reg, 5'b0} | {1'b0, rom_bank_low_reg};
                    end
                end else if (addr[14]) begin
                    dec_bank = {rom_bank_high_reg, rom_bank_low_reg};
                end
            end
        end else if (in_ram) begin
            if (mt == MAP_ROM_ONLY || ram_bank_count_reg == '0) begin
                dec_tgt = TGT_OPEN;
            end else if (op && !ram_enabled_reg) begin
                dec_tgt = TGT_NONE;
            end else begin
                dec_tgt     = TGT_RAM;
                dec_mod     = 1'b1;
                dec_ram_sel = 1'b1;
                dec_rw      = op;
                dec_n       = ROM_CNT_W'(n_ram);
                dec_bank    = (mt == MAP_MBC1 && !banking_mode_reg) ?
                              '0 : BANK_W'(ram_bank_reg);
            end
        end
    end

    // no divide needed when the access needs no reduction, the count is zero, or the bank is already below the count
    assign stat.quick = !dec_mod || (dec_n == '0) || (ROM_CNT_W'(dec_bank) < dec_n);

    // one restoring divide step
    assign rem_shift = {rem_reg[BANK_W-1:0], dvd_reg[BANK_W-1]};
    assign rem_next  = (rem_shift >= dsr_reg) ? (rem_shift - dsr_reg) : rem_shift;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mapper_type_reg    <= MAP_MBC1;
            rom_bank_count_reg <= 10'd2;
            ram_bank_count_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAPPER_TYPE:    mapper_type_reg    <= cfg_data[1:0];
                CFG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg_data;
                CFG_RAM_BANK_COUNT: ram_bank_count_reg <= cfg_data[RAM_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // bank register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_enabled_reg   <= 1'b0;
            rom_bank_low_reg  <= 8'd1;
            rom_bank_high_reg <= 1'b0;
            ram_bank_reg      <= '0;
            banking_mode_reg  <= 1'b0;
        end else if (reg_wr) begin
            if (addr[14:13] == 2'b00) begin
                ram_enabled_reg <= (wdata[3:0] == 4'hA);
            end else if (mt == MAP_MBC1) begin
                case (addr[14:13])
                    2'b01:   rom_bank_low_reg <= (wdata[4:0] == 5'd0) ?
                                                 8'd1 : {3'b0, wdata[4:0]};
                    2'b10:   ram_bank_reg     <= {2'b0, wdata[1:0]};
                    default: banking_mode_reg <= wdata[0];
                endcase
            end else begin
                case (addr[14:12]) inside
                    3'b010:         rom_bank_low_reg  <= wdata;
                    3'b011:         rom_bank_high_reg <= wdata[0];
                    3'b100, 3'b101: ram_bank_reg      <= wdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // item and divider registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tgt_reg     <= dec_tgt;
            base_reg    <= dec_base;
            rw_reg      <= dec_rw;
            mod_reg     <= dec_mod;
            ram_sel_reg <= dec_ram_sel;
            off_reg     <= addr[13:0];
            res_reg     <= (dec_n == '0) ? '0 : dec_bank;
            dvd_reg     <= dec_bank;
            dsr_reg     <= dec_n;
            rem_reg     <= '0;
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[BANK_W-2:0], 1'b0};
            if (cmd.last) begin
                res_reg <= rem_next[BANK_W-1:0];
            end
        end
    end

    // physical address: the direct base, or the reduced bank and the offset
    always_comb begin
        if (!mod_reg) begin
            pa = base_reg;
        end else if (ram_sel_reg) begin
            pa = {1'b0, res_reg, off_reg[12:0]};
        end else begin
            pa = {res_reg, off_reg};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {1'b0, pa};
            m_tuser_reg <= {rw_reg, tgt_reg};
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    // checks
    `CBM_ASSERT_NEXT(a_rem_below_divisor, aclk, aresetn, cmd.step && cmd.last, ROM_CNT_W'(res_reg) < dsr_reg)

endmodule

`default_nettype wire

[test/tb_cartridge_bank_mapper.sv]
// self-checking testbench for cartridge_bank_mapper: directed table, then random bus accesses
// depends on cbm_pkg and the cartridge_bank_mapper rtl; predicts result items in-bench unless a directed row gives them
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper;
    import cbm_pkg::*;

    localparam int          RAND_PHASES  = 10;
    localparam int          PHASE_ITEMS  = 50;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          DIR_ROWS     = 36;
    localparam logic        OP_READ      = 1'b0;
    localparam logic        OP_WRITE     = 1'b1;
    // mapper code with no mapper behind it, decodes as rom only
    localparam logic [1:0]  MAP_SPARE    = 2'd3;

    typedef struct packed {
        target_t     tgt;
        logic [22:0] phys_addr;
        logic        ram_write;
    } access_result_t;

    typedef enum logic {ROW_ACC, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  op;
        logic [15:0]           addr;
        logic [7:0]            wdata;
        logic [CFG_IDX_W-1:0]  cidx;
        logic [CFG_DAT_W-1:0]  cdata;
        logic                  typed;
        access_result_t        want;
    } stim_row_t;

    localparam access_result_t R_NONE = '{TGT_NONE, 23'd0, 1'b0};
    localparam access_result_t R_OPEN = '{TGT_OPEN, 23'd0, 1'b0};

    // directed rows; typed = 0 means the predictor supplies the expectation
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        // reset setting: mbc1, 2 rom banks, no ram
        '{ROW_ACC, OP_READ,  16'h0000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1,
          '{TGT_ROM, 23'h0000, 1'b0}},
        '{ROW_ACC, OP_READ,  16'h7FFF, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1,
          '{TGT_ROM, 23'h7FFF, 1'b0}},
        '{ROW_ACC, OP_READ,  16'hA000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_OPEN},
        '{ROW_ACC, OP_WRITE, 16'hA000, 8'hFF, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_OPEN},
        '{ROW_ACC, OP_READ,  16'hFFFF, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_ROM_BANK_COUNT, 10'd512, 1'b0, R_NONE},
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_RAM_BANK_COUNT, 10'd16, 1'b0, R_NONE},
        // mbc1 registers: enable, bank zero taken as one, ram bank, mode 1
        '{ROW_ACC, OP_WRITE, 16'h0000, 8'h0A, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h2000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h4000, 8'hFF, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h6000, 8'h01, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_READ,  16'h0000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b0, R_NONE},
        '{ROW_ACC, OP_READ,  16'h7FFF, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b0, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'hBFFF, 8'hFF, CFG_MAPPER_TYPE, 10'd0, 1'b0, R_NONE},
        // disable ram: write dropped, read still translated
        '{ROW_ACC, OP_WRITE, 16'h1FFF, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'hA000, 8'h55, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_READ,  16'hA000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b0, R_NONE},
        // mbc5 with counts above the maxima
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_MAPPER_TYPE, 10'(MAP_MBC5), 1'b0, R_NONE},
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_ROM_BANK_COUNT, 10'd1023, 1'b0, R_NONE},
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_RAM_BANK_COUNT, 10'd31, 1'b0, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h2FFF, 8'hFF, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h3000, 8'h01, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h5FFF, 8'h0F, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h6000, 8'hFF, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_READ,  16'h4000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b0, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'h0000, 8'h0A, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_WRITE, 16'hB000, 8'h12, CFG_MAPPER_TYPE, 10'd0, 1'b0, R_NONE},
        // rom only: direct rom, no register writes, no ram
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_MAPPER_TYPE, 10'(MAP_ROM_ONLY), 1'b0,
          R_NONE},
        '{ROW_ACC, OP_READ,  16'h7FFF, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1,
          '{TGT_ROM, 23'h7FFF, 1'b0}},
        '{ROW_ACC, OP_WRITE, 16'h2000, 8'h05, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_NONE},
        '{ROW_ACC, OP_READ,  16'hA000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1, R_OPEN},
        // unused mapper code acts as rom only
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_MAPPER_TYPE, 10'(MAP_SPARE), 1'b0, R_NONE},
        '{ROW_ACC, OP_READ,  16'h4000, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1,
          '{TGT_ROM, 23'h4000, 1'b0}},
        // rom count of zero folds every bank to 0
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_ROM_BANK_COUNT, 10'd0, 1'b0, R_NONE},
        '{ROW_CFG, OP_READ,  16'h0000, 8'h00, CFG_MAPPER_TYPE, 10'(MAP_MBC1), 1'b0, R_NONE},
        '{ROW_ACC, OP_READ,  16'h7FFF, 8'h00, CFG_MAPPER_TYPE, 10'd0, 1'b1,
          '{TGT_ROM, 23'h3FFF, 1'b0}}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // addr[15:0], wdata[23:16]
    logic                 s_tuser;   // op[0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // phys_addr[22:0], zero pad [23]
    logic [2:0]           m_tuser;   // target[1:0], ram_write[2]

    // predictor copy of configuration and bank registers
    logic [1:0]           mapper_sel;
    logic [9:0]           rom_bank_total;
    logic [4:0]           ram_bank_total;
    logic                 ram_on;
    logic [7:0]           rom_sel_lo;
    logic                 rom_sel_hi;
    logic [3:0]           ram_sel;
    logic                 mode_sel;

    access_result_t       awaited_maps [$];
    int                   mismatch_count;
    int                   quiet_cycles;
    bit                   calm_phase;

    cartridge_bank_mapper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // bank number modulo a count clipped to its maximum; count 0 gives bank 0
    function automatic int unsigned fold_bank(input int unsigned bank,
                                              input int unsigned count,
                                              input int unsigned maxc);
        int unsigned n;
        n = (count > maxc) ? maxc : count;
        if (n == 0)
            return 0;
        return bank % n;
    endfunction

    // translate one bus access and apply its register side effects
    function automatic access_result_t map_access(input logic wr, input logic [15:0] a,
                                                  input logic [7:0] v);
        access_result_t res;
        logic [1:0]     mt;
        int unsigned    bank;
        res  = R_NONE;
        bank = 0;
        mt   = (mapper_sel == MAP_MBC1 || mapper_sel == MAP_MBC5) ? mapper_sel
                                                                  : MAP_ROM_ONLY;
        if (a <= 16'h7FFF) begin
            if (wr && mt != MAP_ROM_ONLY) begin
                // bank register writes
                if (a <= 16'h1FFF) begin
                    ram_on = (v[3:0] == 4'hA);
                end else if (mt == MAP_MBC1) begin
                    if (a <= 16'h3FFF)
                        rom_sel_lo = (v[4:0] == 5'd0) ? 8'd1 : {3'd0, v[4:0]};
                    else if (a <= 16'h5FFF)
                        ram_sel = {2'd0, v[1:0]};
                    else
                        mode_sel = v[0];
                end else begin
                    if (a <= 16'h2FFF)
                        rom_sel_lo = v;
                    else if (a <= 16'h3FFF)
                        rom_sel_hi = v[0];
                    else if (a <= 16'h5FFF)
                        ram_sel = v[3:0];
                end
            end else if (!wr) begin
                res.tgt = TGT_ROM;
                if (mt == MAP_ROM_ONLY) begin
                    res.phys_addr = {7'd0, a};
                end else begin
                    if (mt == MAP_MBC1) begin
                        if (a <= 16'h3FFF)
                            bank = mode_sel ? (int'(ram_sel) << 5) : 0;
                        else
                            bank = (int'(ram_sel) << 5) | int'(rom_sel_lo);
                    end else if (a > 16'h3FFF) begin
                        bank = (int'(rom_sel_hi) << 8) | int'(rom_sel_lo);
                    end
                    res.phys_addr = 23'((fold_bank(bank, rom_bank_total, 512) << 14)
                                        | int'(a[13:0]));
                end
            end
        end else if (a >= 16'hA000 && a <= 16'hBFFF) begin
            if (mt == MAP_ROM_ONLY || ram_bank_total == 5'd0) begin
                res.tgt = TGT_OPEN;
            end else if (!(wr && !ram_on)) begin
                bank = (mt == MAP_MBC1 && !mode_sel) ? 0 : int'(ram_sel);
                res.tgt       = TGT_RAM;
                res.phys_addr = 23'((fold_bank(bank, ram_bank_total, 16) << 13)
                                    | int'(a[12:0]));
                res.ram_write = wr;
            end
        end
        return res;
    endfunction

    // present one access item, record its expectation when it is taken
    task automatic send_item(input logic op, input logic [15:0] a, input logic [7:0] v,
                             input logic typed, input access_result_t want);
        int unsigned    gap;
        access_result_t got;
        gap = calm_phase ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, a};
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = map_access(op, a, v);
        awaited_maps.push_back(typed ? want : got);
    endtask

    // register write once every pending result has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_maps.size() != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAPPER_TYPE:    mapper_sel     = val[1:0];
            CFG_ROM_BANK_COUNT: rom_bank_total = val;
            CFG_RAM_BANK_COUNT: ram_bank_total = val[4:0];
            default: ;
        endcase
    endtask

    // result side: random stall before each item, none in calm phases
    initial begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm_phase ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_maps.size() == 0) begin
                $error("result item with none pending: tdata %h tuser %h", m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = awaited_maps.pop_front();
                if (m_tuser[1:0] != want.tgt) begin
                    $error("target: expected %0d, got %0d", want.tgt, m_tuser[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[22:0] != want.phys_addr) begin
                    $error("phys_addr: expected %h, got %h", want.phys_addr, m_tdata[22:0]);
                    mismatch_count++;
                end
                if (m_tuser[2] != want.ram_write) begin
                    $error("ram_write: expected %0d, got %0d", want.ram_write, m_tuser[2]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int unsigned   r;
        logic          op;
        logic [15:0]   a;
        logic [7:0]    v;
        logic [1:0]    mt;
        logic [9:0]    rc;
        logic [4:0]    qc;
        mismatch_count = 0;
        quiet_cycles   = 0;
        calm_phase     = 1'b0;
        mapper_sel     = MAP_MBC1;
        rom_bank_total = 10'd2;
        ram_bank_total = 5'd0;
        ram_on         = 1'b0;
        rom_sel_lo     = 8'd1;
        rom_sel_hi     = 1'b0;
        ram_sel        = 4'd0;
        mode_sel       = 1'b0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAPPER_TYPE;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].cidx, dir_rows[i].cdata);
            else
                send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].wdata,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, each under a fresh mapper setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            r  = $urandom_range(0, 9);
            mt = (r == 0) ? MAP_ROM_ONLY : (r == 1) ? MAP_SPARE
               : (r < 6) ? MAP_MBC1 : MAP_MBC5;
            case ($urandom_range(0, 7))
                0:       rc = 10'd0;
                1:       rc = 10'd1;
                2:       rc = 10'd2;
                3:       rc = 10'd512;
                4:       rc = 10'd1023;
                default: rc = 10'($urandom_range(3, 511));
            endcase
            case ($urandom_range(0, 5))
                0:       qc = 5'd0;
                1:       qc = 5'd1;
                2:       qc = 5'd16;
                3:       qc = 5'd31;
                default: qc = 5'($urandom_range(2, 15));
            endcase
            calm_phase = 1'b0;
            write_reg(CFG_MAPPER_TYPE, 10'(mt));
            write_reg(CFG_ROM_BANK_COUNT, rc);
            write_reg(CFG_RAM_BANK_COUNT, 10'(qc));
            calm_phase = (p % 4 == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                v = 8'($urandom);
                if (r < 30) begin
                    // bank register write, ram enable pattern half the time in the enable range
                    op = OP_WRITE;
                    a  = 16'($urandom_range(0, 16'h7FFF));
                    if (a <= 16'h1FFF && $urandom_range(0, 1) == 1)
                        v = {v[7:4], 4'hA};
                end else if (r < 65) begin
                    op = OP_READ;
                    a  = 16'($urandom_range(0, 16'h7FFF));
                end else if (r < 90) begin
                    op = 1'($urandom_range(0, 1));
                    a  = 16'($urandom_range(16'hA000, 16'hBFFF));
                end else begin
                    op = 1'($urandom_range(0, 1));
                    a  = 16'($urandom);
                end
                send_item(op, a, v, 1'b0, R_NONE);
            end
        end

        // drain and report
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaited_maps.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
